// File: design/cubic_hermite_evaluator_macros.svh
`ifndef CUBIC_HERMITE_EVALUATOR_MACROS_SVH
`define CUBIC_HERMITE_EVALUATOR_MACROS_SVH

// same-cycle implication, off while reset is low
`define CHE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define CHE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define CHE_ASSERT_ALW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/che_pkg.sv
// ----------------------------------------------------------------------------
// che_pkg
// Shared constants, types and helpers of the cubic Hermite spline evaluator.
// ----------------------------------------------------------------------------
package che_pkg;

  // table size and fixed-point format
  localparam int MAX_KNOTS = 64;
  localparam int FRAC_BITS = 16;
  localparam int KAW       = $clog2(MAX_KNOTS);

  // field and datapath widths
  localparam int XW     = 32;                   // external Q16.16 fields
  localparam int DW     = XW + 1;               // knot differences
  localparam int IW     = 63 - FRAC_BITS;       // clipped intermediates
  localparam int NW     = IW - 1 + FRAC_BITS;   // dividend magnitude
  localparam int CNT_W  = 7;                    // knot_count register
  localparam int CFG_AW = 3;

  // intermediate saturation bound
  localparam logic signed [63:0] IBOUND   = (64'sd1 <<< (62 - FRAC_BITS)) - 64'sd1;
  localparam logic signed [63:0] IBOUND_N = -IBOUND;

  // register map
  localparam int REG_KNOT_COUNT = 0;

  // request kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // derivative orders
  localparam logic [1:0] ORD_VALUE  = 2'd0;
  localparam logic [1:0] ORD_FIRST  = 2'd1;
  localparam logic [1:0] ORD_SECOND = 2'd2;
  localparam logic [1:0] ORD_THIRD  = 2'd3;

  typedef struct packed {
    logic signed [XW-1:0] pos;
    logic signed [XW-1:0] val;
    logic signed [XW-1:0] slope;
  } knot_t;

  typedef struct packed {
    logic signed [IW-1:0] value;
    logic                 sat;
  } fx_res_t;

  // symmetric clip to the intermediate bound
  function automatic fx_res_t clip_fx(input logic signed [63:0] v);
    fx_res_t r;
    if (v > IBOUND) begin
      r.value = IBOUND[IW-1:0];
      r.sat   = 1'b1;
    end else if (v < IBOUND_N) begin
      r.value = IBOUND_N[IW-1:0];
      r.sat   = 1'b1;
    end else begin
      r.value = v[IW-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: design/cubic_hermite_evaluator.sv
// ----------------------------------------------------------------------------
// cubic_hermite_evaluator
// Piecewise cubic Hermite spline evaluation on a 64-entry knot memory,
// signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Load request: writes one knot, no result.
// Evaluate request: the result comes after a linear search over the knots
//   (a read state and a compare state per knot) through the knot memory read
//   port, four serial divisions and at most three multiplies.
// One request at a time; a finished result may wait in the output register.
// Reset: synchronous, active low; clears control and sets knot_count to 2;
//   knot memory contents are not cleared.
module cubic_hermite_evaluator import che_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_kind,
  input  logic [5:0]              in_knot_index,
  input  logic signed [XW-1:0]    in_knot_position,
  input  logic signed [XW-1:0]    in_knot_value,
  input  logic signed [XW-1:0]    in_knot_slope,
  input  logic signed [XW-1:0]    in_query_x,
  input  logic [1:0]              in_derivative_order,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [XW-1:0]    out_result_value,
  output logic                    out_saturated,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_AW-1:0]       cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SRD     = 4'd1;
  localparam logic [3:0] S_SCMP    = 4'd2;
  localparam logic [3:0] S_LD0     = 4'd3;
  localparam logic [3:0] S_LD1     = 4'd4;
  localparam logic [3:0] S_LD2     = 4'd5;
  localparam logic [3:0] S_PREP    = 4'd6;
  localparam logic [3:0] S_DF      = 4'd7;
  localparam logic [3:0] S_C2      = 4'd8;
  localparam logic [3:0] S_W_C2    = 4'd9;
  localparam logic [3:0] S_C3      = 4'd10;
  localparam logic [3:0] S_W_C3A   = 4'd11;
  localparam logic [3:0] S_W_C3B   = 4'd12;
  localparam logic [3:0] S_HK      = 4'd13;
  localparam logic [3:0] S_W_MUL   = 4'd14;
  localparam logic [3:0] S_FIN     = 4'd15;

  localparam logic signed [IW-1:0] OUT_MAX = IW'(64'sd2147483647);
  localparam logic signed [IW-1:0] OUT_MIN = -OUT_MAX;

  logic [3:0]           state_r, state_nxt;
  logic [KAW-1:0]       i_r, i_nxt;
  logic signed [XW-1:0] x_r, x_nxt;
  logic [1:0]           order_r, order_nxt;
  knot_t                lo_r, lo_nxt;
  knot_t                hi_r, hi_nxt;
  logic signed [DW-1:0] h_r, h_nxt;
  logic signed [DW-1:0] u_r, u_nxt;
  logic signed [IW-1:0] df_r, df_nxt;
  logic signed [IW-1:0] c2_r, c2_nxt;
  logic signed [IW-1:0] c3_r, c3_nxt;
  logic [1:0]           step_r, step_nxt;
  logic signed [IW-1:0] res_r, res_nxt;
  logic                 flag_r, flag_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [XW-1:0] out_value_r, out_value_nxt;
  logic                 out_sat_r, out_sat_nxt;
  logic [CNT_W-1:0]     knot_count_r;

  // knot memory
  knot_t                knot_mem [MAX_KNOTS];
  knot_t                rd_data_r;
  logic [KAW-1:0]       rd_addr;
  logic                 mem_we;
  logic                 idx_ok;

  // shared arithmetic units
  logic                 div_start, div_done;
  logic signed [IW-1:0] div_num;
  logic signed [DW-1:0] div_den;
  fx_res_t              div_res;
  logic                 mul_start, mul_done;
  logic signed [IW-1:0] mul_b;
  fx_res_t              mul_res;

  // datapath helpers
  logic [CNT_W-1:0]     n_cl;
  logic [KAW-1:0]       n_lim;
  logic signed [DW-1:0] h_w, u_w, dv_w;
  logic signed [63:0]   s0_w, s1_w, v0_w, df_w, c2_w, c3_w;
  logic signed [63:0]   two_c2, addend, sum_w;
  fx_res_t              t1_c, t2_c, c2x2_c, k_c, sum_c;
  logic                 add_sat, last_step;
  logic                 cfg_wr;
  logic                 cfg_hit;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == 1'(REG_KNOT_COUNT));
  assign cfg_prdata = cfg_hit ? 32'(knot_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= CNT_W'(2);
    end else if (cfg_wr && cfg_pready && cfg_hit) begin
      knot_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // usable knot count, last interval index
  always_comb begin
    if (knot_count_r < CNT_W'(2)) begin
      n_cl = CNT_W'(2);
    end else if (knot_count_r > CNT_W'(MAX_KNOTS)) begin
      n_cl = CNT_W'(MAX_KNOTS);
    end else begin
      n_cl = knot_count_r;
    end
    n_lim = KAW'(n_cl - CNT_W'(2));
  end

  assign idx_ok = (int'(in_knot_index) < MAX_KNOTS);

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      knot_mem[in_knot_index[KAW-1:0]] <= '{pos: in_knot_position, val: in_knot_value,
                                            slope: in_knot_slope};
    end
    rd_data_r <= knot_mem[rd_addr];
  end

  // interval terms
  assign h_w  = DW'(hi_r.pos) - DW'(lo_r.pos);
  assign u_w  = DW'(x_r) - DW'(lo_r.pos);
  assign dv_w = DW'(hi_r.val) - DW'(lo_r.val);

  assign s0_w = 64'(lo_r.slope);
  assign s1_w = 64'(hi_r.slope);
  assign v0_w = 64'(lo_r.val);
  assign df_w = 64'(df_r);
  assign c2_w = 64'(c2_r);
  assign c3_w = 64'(c3_r);

  // coefficient numerators
  assign t1_c = clip_fx((s0_w <<< 1) - (df_w + (df_w <<< 1)) + s1_w);
  assign t2_c = clip_fx(s0_w - (df_w <<< 1) + s1_w);

  // horner multiplier operand for the first step
  always_comb begin
    case (order_r)
      ORD_VALUE: k_c = '{value: c3_r, sat: 1'b0};
      ORD_FIRST: k_c = clip_fx(c3_w + (c3_w <<< 1));
      default:   k_c = clip_fx((c3_w <<< 2) + (c3_w <<< 1));
    endcase
  end

  // horner addend per step
  assign two_c2 = c2_w <<< 1;
  assign c2x2_c = clip_fx(two_c2);

  always_comb begin
    add_sat = 1'b0;
    case (step_r)
      2'd0: begin
        case (order_r)
          ORD_VALUE: addend = c2_w;
          ORD_FIRST: addend = two_c2;
          default: begin
            addend  = 64'(c2x2_c.value);
            add_sat = c2x2_c.sat;
          end
        endcase
      end
      2'd1:    addend = s0_w;
      default: addend = v0_w;
    endcase
  end

  assign sum_w     = addend + 64'(mul_res.value);
  assign sum_c     = clip_fx(sum_w);
  assign last_step = (step_r == 2'd2) ||
                     ((step_r == 2'd1) && (order_r == ORD_FIRST)) ||
                     ((step_r == 2'd0) && (order_r == ORD_SECOND));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    x_nxt         = x_r;
    order_nxt     = order_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    h_nxt         = h_r;
    u_nxt         = u_r;
    df_nxt        = df_r;
    c2_nxt        = c2_r;
    c3_nxt        = c3_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    flag_nxt      = flag_r;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    out_valid_nxt = out_valid_r & out_stall;
    mem_we        = 1'b0;
    rd_addr       = i_r;
    div_start     = 1'b0;
    div_num       = t1_c.value;
    div_den       = h_r;
    mul_start     = 1'b0;
    mul_b         = k_c.value;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            mem_we = idx_ok;
          end else begin
            x_nxt     = in_query_x;
            order_nxt = in_derivative_order;
            i_nxt     = '0;
            flag_nxt  = 1'b0;
            state_nxt = S_SRD;
          end
        end
      end
      // interval search: read the next knot, compare it in the cycle after
      S_SRD: begin
        rd_addr   = i_r + 1'b1;
        state_nxt = (i_r < n_lim) ? S_SCMP : S_LD0;
      end
      S_SCMP: begin
        if (x_r > rd_data_r.pos) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_LD0;
        end
      end
      // fetch both ends of the interval
      S_LD0: begin
        rd_addr   = i_r;
        state_nxt = S_LD1;
      end
      S_LD1: begin
        rd_addr   = i_r + 1'b1;
        lo_nxt    = rd_data_r;
        state_nxt = S_LD2;
      end
      S_LD2: begin
        hi_nxt    = rd_data_r;
        state_nxt = S_PREP;
      end
      // width and offset, start the divided difference; zero width gives a flagged zero
      S_PREP: begin
        h_nxt = h_w;
        u_nxt = u_w;
        if (h_w == '0) begin
          res_nxt   = '0;
          flag_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          div_num   = IW'(dv_w);
          div_den   = h_w;
          state_nxt = S_DF;
        end
      end
      S_DF: begin
        if (div_done) begin
          df_nxt    = div_res.value;
          flag_nxt  = flag_r | div_res.sat;
          state_nxt = S_C2;
        end
      end
      S_C2: begin
        flag_nxt  = flag_r | t1_c.sat;
        div_start = 1'b1;
        div_num   = t1_c.value;
        state_nxt = S_W_C2;
      end
      S_W_C2: begin
        if (div_done) begin
          c2_nxt    = -div_res.value;
          flag_nxt  = flag_r | div_res.sat;
          state_nxt = S_C3;
        end
      end
      S_C3: begin
        flag_nxt  = flag_r | t2_c.sat;
        div_start = 1'b1;
        div_num   = t2_c.value;
        state_nxt = S_W_C3A;
      end
      // second division by the width chains straight on
      S_W_C3A: begin
        if (div_done) begin
          flag_nxt  = flag_r | div_res.sat;
          div_start = 1'b1;
          div_num   = div_res.value;
          state_nxt = S_W_C3B;
        end
      end
      S_W_C3B: begin
        if (div_done) begin
          c3_nxt    = div_res.value;
          flag_nxt  = flag_r | div_res.sat;
          state_nxt = S_HK;
        end
      end
      // scaled c3, then horner steps through the multiplier; third order ends on scaled c3
      S_HK: begin
        flag_nxt = flag_r | k_c.sat;
        if (order_r == ORD_THIRD) begin
          res_nxt   = k_c.value;
          state_nxt = S_FIN;
        end else begin
          mul_start = 1'b1;
          mul_b     = k_c.value;
          step_nxt  = 2'd0;
          state_nxt = S_W_MUL;
        end
      end
      S_W_MUL: begin
        if (mul_done) begin
          flag_nxt = flag_r | mul_res.sat | sum_c.sat | add_sat;
          if (last_step) begin
            res_nxt   = sum_c.value;
            state_nxt = S_FIN;
          end else begin
            step_nxt  = step_r + 1'b1;
            mul_start = 1'b1;
            mul_b     = sum_c.value;
          end
        end
      end
      // final 32-bit clip into the output register
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (res_r > OUT_MAX) begin
            out_value_nxt = OUT_MAX[XW-1:0];
            out_sat_nxt   = 1'b1;
          end else if (res_r < OUT_MIN) begin
            out_value_nxt = OUT_MIN[XW-1:0];
            out_sat_nxt   = 1'b1;
          end else begin
            out_value_nxt = res_r[XW-1:0];
            out_sat_nxt   = flag_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= 2'd0;
      flag_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      flag_r      <= flag_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    x_r         <= x_nxt;
    order_r     <= order_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    h_r         <= h_nxt;
    u_r         <= u_nxt;
    df_r        <= df_nxt;
    c2_r        <= c2_nxt;
    c3_r        <= c3_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  che_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .res   (div_res)
  );

  che_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (u_r),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // handshake outputs
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_saturated    = out_sat_r;

endmodule

// File: design/che_div.sv
// ----------------------------------------------------------------------------
// che_div
// Radix-2 restoring divider: (num << FRAC_BITS) / den, truncated toward zero,
// clipped to the intermediate bound. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module che_div import che_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [IW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 done,
  output fx_res_t              res
);

  localparam int CW = $clog2(NW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] dvd_r;
  logic [DW-1:0] dsr_r;
  logic [DW-1:0] rem_r;
  logic [DW:0]   trial;
  logic          ge;
  logic [IW-2:0] num_mag;
  logic [DW-1:0] den_mag;
  logic          q_ovf;
  logic [IW-2:0] q_mag;

  // operand magnitudes
  assign num_mag = num[IW-1] ? (IW-1)'(-num) : num[IW-2:0];
  assign den_mag = den[DW-1] ? DW'(-den) : den;

  // trial subtract
  assign trial = {rem_r, dvd_r[NW-1]};
  assign ge    = (trial >= {1'b0, dsr_r});

  // control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (!busy_r && start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // shift and subtract datapath, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      neg_r <= num[IW-1] ^ den[DW-1];
      dvd_r <= {num_mag, {FRAC_BITS{1'b0}}};
      dsr_r <= den_mag;
      rem_r <= '0;
      cnt_r <= CW'(NW - 1);
    end else if (busy_r) begin
      rem_r <= ge ? DW'(trial - {1'b0, dsr_r}) : trial[DW-1:0];
      dvd_r <= {dvd_r[NW-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // clip and sign
  assign q_ovf     = |dvd_r[NW-1:IW-1];
  assign q_mag     = q_ovf ? '1 : dvd_r[IW-2:0];
  assign res.value = neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign res.sat   = q_ovf;
  assign done      = done_r;

endmodule

// File: design/che_mul.sv
// ----------------------------------------------------------------------------
// che_mul
// Fixed-point multiply (a * b) >> FRAC_BITS on magnitudes, clipped to the
// intermediate bound. Two partial products through one multiplier.
// ----------------------------------------------------------------------------
module che_mul import che_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] a,
  input  logic signed [IW-1:0] b,
  output logic                 done,
  output fx_res_t              res
);

  localparam int BL = (IW - 1) / 2;
  localparam int BH = IW - 1 - BL;
  localparam int PW = DW + IW - 1;

  logic             busy_r, busy_nxt;
  logic             ph_r, ph_nxt;
  logic             done_r, done_nxt;
  logic             neg_r;
  logic [DW-1:0]    am_r;
  logic [IW-2:0]    bm_r;
  logic [PW-1:0]    acc_r;
  logic [BH-1:0]    bpart;
  logic [DW+BH-1:0] prod;
  logic             ovf;
  logic [IW-2:0]    mag;

  // control
  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    if (!busy_r && start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 1'b0;
    end else if (busy_r && !ph_r) begin
      ph_nxt = 1'b1;
    end else if (busy_r) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  // partial product, low half then high half of b
  assign bpart = ph_r ? BH'(bm_r[IW-2:BL]) : BH'(bm_r[BL-1:0]);
  assign prod  = am_r * bpart;

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      neg_r <= a[DW-1] ^ b[IW-1];
      am_r  <= a[DW-1] ? DW'(-a) : a;
      bm_r  <= b[IW-1] ? (IW-1)'(-b) : b[IW-2:0];
    end else if (busy_r && !ph_r) begin
      acc_r <= PW'(prod);
    end else if (busy_r) begin
      acc_r <= acc_r + (PW'(prod) << BL);
    end
  end

  // scale, clip and sign
  assign ovf       = |acc_r[PW-1:FRAC_BITS+IW-1];
  assign mag       = ovf ? '1 : acc_r[FRAC_BITS+IW-2:FRAC_BITS];
  assign res.value = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign res.sat   = ovf;
  assign done      = done_r;

endmodule

// File: design/che_chk.sv
// ----------------------------------------------------------------------------
// che_chk
// Port-level checks for the cubic Hermite spline evaluator, bound to the top.
// ----------------------------------------------------------------------------
`include "cubic_hermite_evaluator_macros.svh"

module che_chk import che_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_kind,
  input logic              out_valid,
  input logic              out_stall,
  input logic [XW-1:0]     out_result_value,
  input logic              out_saturated
);

  // no result survives reset
  `CHE_ASSERT_ALW(a_rst_clear, clk, !rst_n, !out_valid, "result valid after reset")

  // a stalled result stays offered and unchanged
  `CHE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `CHE_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall,
    $stable(out_result_value) && $stable(out_saturated), "stalled result changed")

  // the most negative code never appears on an unflagged result
  `CHE_ASSERT_IMP(a_min_flag, clk, rst_n, out_valid && !out_saturated,
    out_result_value != 32'h80000000, "unflagged negative full scale")

  // an evaluate request never finishes on the next cycle
  `CHE_ASSERT_NXT(a_eval_lat, clk, rst_n, in_valid && !in_stall && (in_kind == KIND_EVAL),
    !$rose(out_valid), "evaluate finished too early")

endmodule

bind cubic_hermite_evaluator che_chk u_che_chk (.*);
